// File: rtl/core/oirt_pkg.sv
package oirt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 31;
  localparam int SCORE_W   = 16;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   new_key;
    logic [SCORE_W-1:0] new_score;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   entry_key;
    logic [SCORE_W-1:0] entry_score;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } out_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;  // ordered insert: compare stored key against the new key
    logic wr_en;   // a record is written this cycle
    logic rot_en;  // rotate the occupied cells toward the head by one
  } cell_ctrl_t;

endpackage

// File: rtl/core/ordered_insert_record_table_unit.sv
// Bounded table of up to DEPTH key/score records held in a chain of cells.
// On an ordered insert all cells compare their key with the new key at once
// and the cell chain shifts the later records up; an append writes the tail
// cell. The result appears in the output register on the next cycle. A full table
// drops the record and reports it. A dump delivers the stored records from the
// head, or one empty report when the table holds none: the occupied
// cells rotate toward the head once per delivered result, and the input is
// stalled until the last record has been loaded into the output register. A
// new transaction is accepted whenever the block is not dumping and the
// output register is free or being drained.
module ordered_insert_record_table_unit #(
  parameter int DEPTH = oirt_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  oirt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output oirt_pkg::out_t out_data_o
);
  import oirt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_valid_q;
  out_t               out_q, out_d;
  logic               out_load;

  logic               out_free, accept, full, dump_last;
  op_e                op;
  cell_ctrl_t         ctrl;
  logic [COUNT_W-1:0] cnt_ext;

  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [SCORE_W-1:0] cell_score [DEPTH];
  logic               shift      [DEPTH+1];
  logic [POS_W-1:0]   pos        [DEPTH+1];

  assign op        = op_e'(in_data_i.opcode);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && out_free);
  assign accept    = in_valid_i && !in_stall_o;
  assign full      = cnt_q == FULL_CNT;
  assign cnt_ext   = COUNT_W'(cnt_q);
  assign dump_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

  assign ctrl.cmp_en = (op == OP_INSERT);
  assign ctrl.wr_en  = accept && (op == OP_APPEND || op == OP_INSERT) && !full;
  assign ctrl.rot_en = (state_q == S_DUMP) && out_free;

  assign shift[0] = 1'b0;
  assign pos[0]   = cnt_ext[POS_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]   pk, nk;
    logic [SCORE_W-1:0] ps, ns;
    if (i == 0) begin : g_head
      assign pk = in_data_i.new_key;
      assign ps = in_data_i.new_score;
    end else begin : g_body
      assign pk = cell_key[i-1];
      assign ps = cell_score[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign nk = cell_key[i];
      assign ns = cell_score[i];
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign ns = cell_score[i+1];
    end
    oirt_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (cnt_q),
      .new_key_i    (in_data_i.new_key),
      .new_score_i  (in_data_i.new_score),
      .prev_key_i   (pk),
      .prev_score_i (ps),
      .next_key_i   (nk),
      .next_score_i (ns),
      .head_key_i   (cell_key[0]),
      .head_score_i (cell_score[0]),
      .shift_i      (shift[i]),
      .pos_i        (pos[i]),
      .shift_o      (shift[i+1]),
      .pos_o        (pos[i+1]),
      .key_o        (cell_key[i]),
      .score_o      (cell_score[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op == OP_DUMP && cnt_q != '0) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs, fill count and dump index.
  always_comb begin
    out_load          = 1'b0;
    out_d             = out_q;
    cnt_d             = cnt_q;
    idx_d             = idx_q;
    out_d.status      = ST_OK;
    out_d.last        = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          out_d.entry_key   = in_data_i.new_key;
          out_d.entry_score = in_data_i.new_score;
          out_d.position    = '0;
          out_d.entry_count = cnt_ext;
          unique case (op)
            OP_APPEND, OP_INSERT: begin
              out_load = 1'b1;
              if (full) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.position    = pos[DEPTH];
                out_d.entry_count = cnt_ext + COUNT_W'(1);
                cnt_d             = cnt_q + CNT_W'(1);
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                out_load          = 1'b1;
                out_d.status      = ST_EMPTY;
                out_d.entry_key   = '0;
                out_d.entry_score = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.position    = POS_W'(idx_q);
          out_d.entry_key   = cell_key[0];
          out_d.entry_score = cell_score[0];
          out_d.entry_count = cnt_ext;
          out_d.last        = dump_last;
          idx_d             = idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/oirt_cell.sv
module oirt_cell #(
  parameter int DEPTH = oirt_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                                   clk_i,
  input  oirt_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]             count_i,
  input  logic [oirt_pkg::KEY_W-1:0]             new_key_i,
  input  logic [oirt_pkg::SCORE_W-1:0]           new_score_i,
  input  logic [oirt_pkg::KEY_W-1:0]             prev_key_i,
  input  logic [oirt_pkg::SCORE_W-1:0]           prev_score_i,
  input  logic [oirt_pkg::KEY_W-1:0]             next_key_i,
  input  logic [oirt_pkg::SCORE_W-1:0]           next_score_i,
  input  logic [oirt_pkg::KEY_W-1:0]             head_key_i,
  input  logic [oirt_pkg::SCORE_W-1:0]           head_score_i,
  input  logic                                   shift_i,
  input  logic [oirt_pkg::POS_W-1:0]             pos_i,
  output logic                                   shift_o,
  output logic [oirt_pkg::POS_W-1:0]             pos_o,
  output logic [oirt_pkg::KEY_W-1:0]             key_o,
  output logic [oirt_pkg::SCORE_W-1:0]           score_o
);
  import oirt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic [KEY_W-1:0]   key_q, key_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               occ, at_tail, last_occ, gt;

  assign occ      = MY_IDX < count_i;
  assign at_tail  = MY_IDX == count_i;
  assign last_occ = MY_NEXT == count_i;
  assign gt       = ctrl_i.cmp_en && occ && (key_q > new_key_i);

  // The first cell holding a greater key takes the new record; every cell
  // after it takes its left neighbor's record.
  assign shift_o = shift_i | gt;
  assign pos_o   = (!shift_i && gt) ? POS_W'(IDX) : pos_i;

  always_comb begin
    key_d   = key_q;
    score_d = score_q;
    if (ctrl_i.wr_en) begin
      if (shift_i) begin
        key_d   = prev_key_i;
        score_d = prev_score_i;
      end else if (gt || at_tail) begin
        key_d   = new_key_i;
        score_d = new_score_i;
      end
    end else if (ctrl_i.rot_en) begin
      if (last_occ) begin
        key_d   = head_key_i;
        score_d = head_score_i;
      end else if (occ) begin
        key_d   = next_key_i;
        score_d = next_score_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    score_q <= score_d;
  end

  assign key_o   = key_q;
  assign score_o = score_q;

endmodule

// File: rtl/core/oirt_check.sv
module oirt_check #(
  parameter int DEPTH = oirt_pkg::DEPTH_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input oirt_pkg::out_t out_data_o
);
  import oirt_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(DEPTH);

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= MAX_CNT)
    else $error("entry count above table depth");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.entry_count == MAX_CNT && out_data_o.position == '0 && out_data_o.last)
    else $error("dropped record reported with wrong fields");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.entry_count == '0 && out_data_o.last)
    else $error("empty dump reported with wrong fields");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK |->
      COUNT_W'(out_data_o.position) < out_data_o.entry_count)
    else $error("position outside held entries");

endmodule

bind ordered_insert_record_table_unit oirt_check #(.DEPTH(DEPTH)) u_oirt_check (.*);

// File: bench/tb_ordered_insert_record_table_unit.sv
module tb_ordered_insert_record_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import oirt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_n_q = 1'b0;
  logic in_valid_q = 1'b0;
  in_t in_data_q = '0;
  logic out_stall_q = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  // Shadow copy of the table, updated as each transaction is accepted.
  logic [KEY_W-1:0] tbl_key[TABLE_DEPTH];
  logic [SCORE_W-1:0] tbl_score[TABLE_DEPTH];
  int tbl_count = 0;
  out_t table_results_due[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int items_accepted = 0;
  int burst_left = 0;
  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;
  int hold_off_len = 0;
  bit holding_off = 1'b0;
  int stall_run_left = 0;
  bit stall_phase = 1'b0;

  ordered_insert_record_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n_q),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_q),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void apply_table_op(in_t item);
    out_t r;
    int slot;
    int i;
    r = '0;
    r.last = 1'b1;
    case (item.opcode)
      OP_APPEND, OP_INSERT: begin
        r.entry_key = item.new_key;
        r.entry_score = item.new_score;
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          r.entry_count = COUNT_W'(TABLE_DEPTH);
        end else begin
          slot = tbl_count;
          if (item.opcode == OP_INSERT) begin
            // Walking down leaves slot at the first strictly greater key.
            for (i = tbl_count - 1; i >= 0; i--) begin
              if (tbl_key[i] > item.new_key) slot = i;
            end
            for (i = tbl_count; i > slot; i--) begin
              tbl_key[i] = tbl_key[i-1];
              tbl_score[i] = tbl_score[i-1];
            end
          end
          tbl_key[slot] = item.new_key;
          tbl_score[slot] = item.new_score;
          tbl_count++;
          r.status = ST_OK;
          r.position = POS_W'(slot);
          r.entry_count = COUNT_W'(tbl_count);
        end
        table_results_due.push_back(r);
      end
      OP_DUMP: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
          table_results_due.push_back(r);
        end else begin
          for (i = 0; i < tbl_count; i++) begin
            r.status = ST_OK;
            r.position = POS_W'(i);
            r.entry_key = tbl_key[i];
            r.entry_score = tbl_score[i];
            r.entry_count = COUNT_W'(tbl_count);
            r.last = (i == tbl_count - 1);
            table_results_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return KEY_MAX;
      2, 3: return KEY_W'($urandom_range(0, 15));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Offers one transaction and returns at the edge where it was taken, with
  // valid still high so that a following call keeps the channel busy.
  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [SCORE_W-1:0] score);
    in_t item;
    item.opcode = op;
    item.new_key = key;
    item.new_score = score;
    if (sender_gaps_on && burst_left == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_q <= 1'b1;
    in_data_q <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_table_op(item);
    items_accepted++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic test_directed_cases();
    send_item(OP_DUMP, KEY_MAX, 16'hFFFF);
    send_item(OP_INSERT, KEY_MAX, 16'hFFFF);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_INSERT, '0, 16'h1234);
    // An equal key is not greater, so it lands after the stored one.
    send_item(OP_INSERT, KEY_MAX, 16'h0000);
    send_item(OP_IGNORED, rand_key(), 16'($urandom));
    send_item(OP_INSERT, 31'h4000_0000, 16'h8000);
    send_item(OP_DUMP, '0, '0);
  endtask

  task automatic test_ordered_placement();
    send_item(OP_INSERT, 31'd1, 16'h0001);
    send_item(OP_APPEND, 31'd7, 16'h0002);
    send_item(OP_INSERT, 31'h7FFF_FFFE, 16'h0003);
    send_item(OP_INSERT, 31'd3, 16'h0004);
    send_item(OP_DUMP, rand_key(), 16'($urandom));
    repeat (2) send_item(OP_INSERT, KEY_W'($urandom_range(0, 8)), 16'($urandom));
    send_item(OP_DUMP, '0, '0);
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    logic [1:0] op;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      sender_gaps_on = ((counted / 100) % 2) == 0;
      receiver_stalls_on = (counted / 100) < 3;
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_INSERT;
      else if (pick < 60) op = OP_APPEND;
      else if (pick < 94) op = OP_DUMP;
      else op = OP_IGNORED;
      send_item(op, rand_key(), 16'($urandom));
      if (op != OP_IGNORED) counted++;
    end
  endtask

  task automatic test_full_table();
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    while (tbl_count < TABLE_DEPTH) send_item(OP_APPEND, rand_key(), 16'($urandom));
    send_item(OP_APPEND, KEY_MAX, 16'hFFFF);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_DUMP, KEY_MAX, 16'hFFFF);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the output register fills and the input stalls.
  task automatic test_backpressure_fill();
    sender_gaps_on = 1'b0;
    in_valid_q <= 1'b0;
    hold_off_len = 150;
    do @(posedge clk_i); while (!holding_off);
    repeat (6) begin
      send_item(OP_DUMP, rand_key(), 16'($urandom));
      send_item(OP_INSERT, rand_key(), 16'($urandom));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        holding_off = 1'b1;
        out_stall_q <= 1'b1;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
        holding_off = 1'b0;
        out_stall_q <= 1'b0;
        stall_phase = 1'b0;
        stall_run_left = 0;
      end else if (stall_run_left == 0) begin
        stall_phase = !stall_phase && receiver_stalls_on;
        stall_run_left = stall_phase ? $urandom_range(1, 6) : $urandom_range(1, 10);
        out_stall_q <= stall_phase;
      end else begin
        stall_run_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_n_q && out_valid_o && !out_stall_q) begin
      if (table_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result st=%0d pos=%0d key=%h score=%h cnt=%0d last=%b",
                 $time, out_data_o.status, out_data_o.position, out_data_o.entry_key,
                 out_data_o.entry_score, out_data_o.entry_count, out_data_o.last);
      end else begin
        want = table_results_due.pop_front();
        results_checked++;
        if (out_data_o !== want) begin
          mismatch_count++;
          $display("%0t: expected st=%0d pos=%0d key=%h score=%h cnt=%0d last=%b",
                   $time, want.status, want.position, want.entry_key,
                   want.entry_score, want.entry_count, want.last);
          $display("%0t: actual   st=%0d pos=%0d key=%h score=%h cnt=%0d last=%b",
                   $time, out_data_o.status, out_data_o.position, out_data_o.entry_key,
                   out_data_o.entry_score, out_data_o.entry_count, out_data_o.last);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("%0t: timeout with %0d results outstanding", $time, table_results_due.size());
    $display("[ordered_insert_record_table_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n_q <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_ordered_placement();
    test_random_traffic();
    test_full_table();
    test_backpressure_fill();
    in_valid_q <= 1'b0;
    while (table_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Accepted %0d transactions and checked %0d results, covering ordered inserts,",
             items_accepted, results_checked);
    $display("appends, dumps of an empty and a full table, dropped records and backpressure.");
    if (mismatch_count == 0) begin
      $display("[ordered_insert_record_table_unit] OK");
    end else begin
      $display("[ordered_insert_record_table_unit] ERROR");
    end
    $finish;
  end

endmodule
